// ===== sv/hte_pkg.sv =====
`default_nettype none

package hte_pkg;

  // one accepted input byte
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } hte_item_t;

  // one result item
  typedef struct packed {
    logic [7:0] char_out;
    logic       error;
    logic       last_of_run;
  } hte_result_t;

  // results from one parsed byte, res0 goes out first
  typedef struct packed {
    logic [1:0]  count;
    hte_result_t res1;
    hte_result_t res0;
  } hte_push_t;

  localparam int unsigned ResultQDepth = 4;

  localparam logic [7:0] CharSpace   = " ";
  localparam logic [7:0] CharLess    = "<";
  localparam logic [7:0] CharGreater = ">";
  localparam logic [7:0] CharAmp     = "&";
  localparam logic [7:0] CharSemi    = ";";
  localparam logic [7:0] CharSlash   = "/";
  localparam logic [7:0] CharNull    = 8'h00;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] PrintHigh   = 8'h7E;

  localparam logic [2:0] ScriptLen   = 3'd6;
  localparam logic [2:0] StyleLen    = 3'd5;
  localparam logic [3:0] EndScriptLen = 4'd9;
  localparam logic [3:0] EndStyleLen  = 4'd8;

  function automatic logic [7:0] script_at(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = "s";
      3'd1:    ch = "c";
      3'd2:    ch = "r";
      3'd3:    ch = "i";
      3'd4:    ch = "p";
      3'd5:    ch = "t";
      default: ch = CharNull;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] style_at(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = "s";
      3'd1:    ch = "t";
      3'd2:    ch = "y";
      3'd3:    ch = "l";
      3'd4:    ch = "e";
      default: ch = CharNull;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_script_at(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = CharLess;
      4'd1:    ch = CharSlash;
      4'd2:    ch = "s";
      4'd3:    ch = "c";
      4'd4:    ch = "r";
      4'd5:    ch = "i";
      4'd6:    ch = "p";
      4'd7:    ch = "t";
      4'd8:    ch = CharGreater;
      default: ch = CharNull;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_style_at(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = CharLess;
      4'd1:    ch = CharSlash;
      4'd2:    ch = "s";
      4'd3:    ch = "t";
      4'd4:    ch = "y";
      4'd5:    ch = "l";
      4'd6:    ch = "e";
      4'd7:    ch = CharGreater;
      default: ch = CharNull;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hte_in_if.sv =====
`default_nettype none

interface hte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/hte_out_if.sv =====
`default_nettype none

interface hte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       error;
  logic       last_of_run;

  modport source (output valid, output char_out, output error, output last_of_run,
                  input ready);
  modport sink (input valid, input char_out, input error, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// ===== sv/html_text_extractor_core.sv =====
`default_nettype none

// Streaming HTML visible-text extractor. Takes one document byte per cycle
// while the result queue has room and delivers the extracted characters, one
// result per cycle on the output channel while the sink is ready. A byte is
// held in the input register, parsed in the following cycle by single-level
// state logic, and its results (none, one, or two for the byte that closes a
// script or style block) are written into a four-entry result queue, so the
// first result of a byte passes the input register and the queue before it
// appears. Sustained rate is one byte per cycle while the sink takes one
// result per cycle; the second result of a byte that yields two waits in the
// queue. Input is stalled only when the queue holds more than two results.
// At most EntityScanLimit-1 bytes after '&' may precede ';'.
module html_text_extractor_core #(
  parameter int unsigned EntityScanLimit = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hte_in_if.sink    in_i,
  hte_out_if.source out_o
);

  hte_pkg::hte_item_t item;
  logic               item_valid;
  logic               take;
  logic               room;
  hte_pkg::hte_push_t push;

  hte_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .item_o  (item),
    .valid_o (item_valid)
  );

  hte_parser #(
    .EntityScanLimit (EntityScanLimit)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .item_i  (item),
    .room_i  (room),
    .take_o  (take),
    .push_o  (push)
  );

  hte_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/hte_in_reg.sv =====
`default_nettype none

module hte_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  hte_in_if.sink             in_i,
  input  wire logic          take_i,
  output hte_pkg::hte_item_t item_o,
  output logic               valid_o
);

  logic               valid_q, valid_d;
  hte_pkg::hte_item_t item_q;
  logic               accept;

  // refill in the same cycle the parser consumes the held byte
  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.byte_in   <= in_i.byte_in;
      item_q.last_byte <= in_i.last_byte;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/hte_parser.sv =====
`default_nettype none

module hte_parser #(
  parameter int unsigned EntityScanLimit = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire hte_pkg::hte_item_t  item_i,
  input  wire logic                room_i,
  output logic                     take_o,
  output hte_pkg::hte_push_t       push_o
);

  localparam int unsigned CntW = $clog2(EntityScanLimit);

  localparam logic [2:0] ModeText   = 3'd0;
  localparam logic [2:0] ModeHead   = 3'd1;
  localparam logic [2:0] ModeTag    = 3'd2;
  localparam logic [2:0] ModeScript = 3'd3;
  localparam logic [2:0] ModeStyle  = 3'd4;
  localparam logic [2:0] ModeEntity = 3'd5;
  localparam logic [2:0] ModeError  = 3'd6;

  localparam logic [2:0] NameNone = 3'd0;
  localparam logic [2:0] NameL    = 3'd1;
  localparam logic [2:0] NameLt   = 3'd2;
  localparam logic [2:0] NameG    = 3'd3;
  localparam logic [2:0] NameGt   = 3'd4;
  localparam logic [2:0] NameA    = 3'd5;
  localparam logic [2:0] NameAm   = 3'd6;
  localparam logic [2:0] NameAmp  = 3'd7;

  function automatic logic [2:0] name_next(input logic [2:0] st, input logic empty,
                                           input logic [7:0] ch);
    logic [2:0] nx;
    nx = NameNone;
    if (empty) begin
      if (ch == "l") nx = NameL;
      else if (ch == "g") nx = NameG;
      else if (ch == "a") nx = NameA;
    end else begin
      if (st == NameL && ch == "t") nx = NameLt;
      else if (st == NameG && ch == "t") nx = NameGt;
      else if (st == NameA && ch == "m") nx = NameAm;
      else if (st == NameAm && ch == "p") nx = NameAmp;
    end
    return nx;
  endfunction

  logic [2:0]      mode_q, mode_d;
  logic [2:0]      head_pos_q, head_pos_d;
  logic [1:0]      head_cand_q, head_cand_d;
  logic [3:0]      close_pos_q, close_pos_d;
  logic [CntW-1:0] ent_cnt_q, ent_cnt_d;
  logic [2:0]      ent_name_q, ent_name_d;

  logic [7:0]      b;
  logic            lst;
  logic            clr;
  logic [1:0]      cand;
  logic [2:0]      p1;
  logic [3:0]      q1;
  logic [CntW:0]   cnt1;
  logic            empty;
  logic [1:0]      e_cnt;
  logic [7:0]      e_char;
  logic            e_err;
  logic            l_emit;
  logic [7:0]      l_char;
  logic            l_err;
  logic [1:0]      n_res;

  assign take_o = valid_i && room_i;

  always_comb begin
    b           = item_i.byte_in;
    lst         = item_i.last_byte;
    mode_d      = mode_q;
    head_pos_d  = head_pos_q;
    head_cand_d = head_cand_q;
    close_pos_d = close_pos_q;
    ent_cnt_d   = ent_cnt_q;
    ent_name_d  = ent_name_q;
    clr         = 1'b0;
    cand        = 2'b00;
    p1          = head_pos_q + 3'd1;
    q1          = close_pos_q + 4'd1;
    cnt1        = {1'b0, ent_cnt_q} + (CntW + 1)'(1);
    empty       = (ent_cnt_q == '0);
    e_cnt       = 2'd0;
    e_char      = hte_pkg::CharSpace;
    e_err       = 1'b0;
    l_emit      = 1'b0;
    l_char      = hte_pkg::CharSpace;
    l_err       = 1'b0;

    case (mode_q)
      ModeText: begin
        if (b == hte_pkg::CharLess) begin
          mode_d      = ModeHead;
          head_pos_d  = 3'd0;
          head_cand_d = 2'b11;
        end else if (b == hte_pkg::CharAmp) begin
          mode_d     = ModeEntity;
          ent_cnt_d  = '0;
          ent_name_d = NameNone;
        end else if (b >= hte_pkg::PrintLow && b <= hte_pkg::PrintHigh) begin
          e_cnt  = 2'd1;
          e_char = b;
        end
      end
      ModeHead: begin
        if (head_cand_q[0] && head_pos_q < hte_pkg::ScriptLen &&
            b == hte_pkg::script_at(head_pos_q)) begin
          cand[0] = 1'b1;
        end
        if (head_cand_q[1] && head_pos_q < hte_pkg::StyleLen &&
            b == hte_pkg::style_at(head_pos_q)) begin
          cand[1] = 1'b1;
        end
        if (cand == 2'b00) begin
          if (b == hte_pkg::CharGreater) begin
            e_cnt  = 2'd1;
            mode_d = ModeText;
            clr    = 1'b1;
          end else begin
            mode_d = ModeTag;
          end
        end else if (cand[0] && p1 >= hte_pkg::ScriptLen) begin
          mode_d      = ModeScript;
          close_pos_d = 4'd0;
        end else if (cand[1] && p1 >= hte_pkg::StyleLen) begin
          mode_d      = ModeStyle;
          close_pos_d = 4'd0;
        end else begin
          head_pos_d  = p1;
          head_cand_d = cand;
        end
      end
      ModeTag: begin
        if (b == hte_pkg::CharGreater) begin
          e_cnt  = 2'd1;
          mode_d = ModeText;
          clr    = 1'b1;
        end
      end
      ModeScript: begin
        if (close_pos_q < hte_pkg::EndScriptLen &&
            b == hte_pkg::end_script_at(close_pos_q)) begin
          if (q1 >= hte_pkg::EndScriptLen) begin
            e_cnt  = 2'd2;
            mode_d = ModeText;
            clr    = 1'b1;
          end else begin
            close_pos_d = q1;
          end
        end else begin
          close_pos_d = (b == hte_pkg::CharLess) ? 4'd1 : 4'd0;
        end
      end
      ModeStyle: begin
        if (close_pos_q < hte_pkg::EndStyleLen &&
            b == hte_pkg::end_style_at(close_pos_q)) begin
          if (q1 >= hte_pkg::EndStyleLen) begin
            e_cnt  = 2'd2;
            mode_d = ModeText;
            clr    = 1'b1;
          end else begin
            close_pos_d = q1;
          end
        end else begin
          close_pos_d = (b == hte_pkg::CharLess) ? 4'd1 : 4'd0;
        end
      end
      ModeEntity: begin
        if (b == hte_pkg::CharSemi) begin
          e_cnt = 2'd1;
          clr   = 1'b1;
          if (!empty && ent_name_q == NameLt) begin
            e_char = hte_pkg::CharLess;
            mode_d = ModeText;
          end else if (!empty && ent_name_q == NameGt) begin
            e_char = hte_pkg::CharGreater;
            mode_d = ModeText;
          end else if (!empty && ent_name_q == NameAmp) begin
            e_char = hte_pkg::CharAmp;
            mode_d = ModeText;
          end else begin
            e_char = hte_pkg::CharNull;
            e_err  = 1'b1;
            mode_d = ModeError;
          end
        end else if (cnt1 >= (CntW + 1)'(EntityScanLimit)) begin
          e_cnt  = 2'd1;
          e_char = hte_pkg::CharNull;
          e_err  = 1'b1;
          mode_d = ModeError;
          clr    = 1'b1;
        end else begin
          ent_name_d = name_next(ent_name_q, empty, b);
          ent_cnt_d  = cnt1[CntW-1:0];
        end
      end
      default: begin
        mode_d = ModeError;
      end
    endcase

    // end of document: close whatever is still open
    if (lst) begin
      if (mode_d == ModeHead || mode_d == ModeTag || mode_d == ModeScript ||
          mode_d == ModeStyle) begin
        l_emit = 1'b1;
      end else if (mode_d == ModeEntity) begin
        l_emit = 1'b1;
        l_char = hte_pkg::CharNull;
        l_err  = 1'b1;
      end
      mode_d = ModeText;
      clr    = 1'b1;
    end

    if (clr) begin
      head_pos_d  = 3'd0;
      head_cand_d = 2'b11;
      close_pos_d = 4'd0;
      ent_cnt_d   = '0;
      ent_name_d  = NameNone;
    end
  end

  assign n_res = e_cnt + {1'b0, l_emit};

  always_comb begin
    push_o.count = take_o ? n_res : 2'd0;
    if (e_cnt != 2'd0) begin
      push_o.res0.char_out = e_char;
      push_o.res0.error    = e_err;
    end else begin
      push_o.res0.char_out = l_char;
      push_o.res0.error    = l_err;
    end
    if (e_cnt == 2'd2) begin
      push_o.res1.char_out = e_char;
      push_o.res1.error    = e_err;
    end else begin
      push_o.res1.char_out = l_char;
      push_o.res1.error    = l_err;
    end
    push_o.res0.last_of_run = (n_res == 2'd1);
    push_o.res1.last_of_run = (n_res == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeText;
      head_pos_q  <= 3'd0;
      head_cand_q <= 2'b11;
      close_pos_q <= 4'd0;
      ent_cnt_q   <= '0;
      ent_name_q  <= NameNone;
    end else if (take_o) begin
      mode_q      <= mode_d;
      head_pos_q  <= head_pos_d;
      head_cand_q <= head_cand_d;
      close_pos_q <= close_pos_d;
      ent_cnt_q   <= ent_cnt_d;
      ent_name_q  <= ent_name_d;
    end
  end

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.last_byte |=> mode_q == ModeText && ent_cnt_q == '0 &&
                                   close_pos_q == 4'd0)
    else $error("state not cleared after last byte");

  a_two_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> (mode_q == ModeScript || mode_q == ModeStyle) &&
                             !push_o.res0.error && !push_o.res1.error)
    else $error("double result outside a closing script or style tag");

endmodule

`default_nettype wire

// ===== sv/hte_out_fifo.sv =====
`default_nettype none

module hte_out_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hte_pkg::hte_push_t push_i,
  output logic                    room_o,
  hte_out_if.source               out_o
);

  localparam int unsigned Depth = hte_pkg::ResultQDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hte_pkg::hte_result_t mem [Depth];
  logic [PtrW-1:0]      wptr_q, wptr_d;
  logic [PtrW-1:0]      rptr_q, rptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pop;
  hte_pkg::hte_result_t head;

  assign pop    = out_o.valid && out_o.ready;
  // room for the largest burst one byte can cause
  assign room_o = cnt_q <= CntW'(Depth - 2);

  always_comb begin
    wptr_d = PtrW'(wptr_q + PtrW'(push_i.count));
    rptr_d = PtrW'(rptr_q + PtrW'(pop));
    cnt_d  = CntW'(cnt_q + CntW'(push_i.count) - CntW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem[PtrW'(wptr_q + PtrW'(1))] <= push_i.res1;
    end
  end

  assign head              = mem[rptr_q];
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.char_out    = head.char_out;
  assign out_o.error       = head.error;
  assign out_o.last_of_run = head.last_of_run;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o && push_i.count != 2'd3)
    else $error("result queue written without room");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth) && (cnt_q == '0 || cnt_q == CntW'(Depth) ||
                              PtrW'(rptr_q + PtrW'(cnt_q)) == wptr_q))
    else $error("result queue count out of step with pointers");

endmodule

`default_nettype wire
